// ===== rtl/core/comb_resonator_fractional_delay_macros.svh =====
// Assertion helpers shared by the resonator RTL.
// Each macro expects i_clk and i_rst_n to exist in the scope that uses it.
`ifndef COMB_RESONATOR_FRACTIONAL_DELAY_MACROS_SVH
`define COMB_RESONATOR_FRACTIONAL_DELAY_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define CRFD_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// A consequence that must hold at the clock edge that follows the antecedent.
`define CRFD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/crfd_pkg.sv =====
package crfd_pkg;

    // Delay line geometry (power of two depth).
    localparam int STORE_DEPTH = 32768;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int D_MAX       = STORE_DEPTH - 2;

    // Field and register widths.
    localparam int SAMPLE_W   = 24;
    localparam int STATE_W    = 32;
    localparam int DELAY_W    = 15;
    localparam int COEF_W     = 17;
    localparam int GAIN_W     = 18;
    localparam int X_W        = 27;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Shared multiplier operand and product widths.
    localparam int MUL_A_W = 24;
    localparam int MUL_B_W = 33;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int WIDE_W  = PROD_W + 1;

    // Q16 unity; a coefficient at or above it bypasses its filter.
    localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(65536);

    // Register reset values.
    localparam logic [DELAY_W-1:0]           RST_DELAY_INT  = DELAY_W'(436);
    localparam logic signed [SAMPLE_W-1:0]   RST_MIX_GAIN   = SAMPLE_W'(8388607);
    localparam logic [GAIN_W-1:0]            RST_INPUT_GAIN = GAIN_W'(65536);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY_INT    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_ALLPASS_COEF = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_MIX_GAIN     = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_COEF    = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_TOPOLOGY     = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_GAIN   = CFG_IDX_W'(5);

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_X_MUL,
        ST_AP_MUL,
        ST_AP_ADD,
        ST_LP_MUL,
        ST_LP_ADD,
        ST_MIX_MUL,
        ST_MIX_ADD
    } t_state;

    // Arithmetic shift right by s with round half up.
    function automatic logic signed [WIDE_W-1:0] round_shift(
        input logic signed [WIDE_W-1:0] v,
        input int unsigned              s
    );
        logic signed [WIDE_W-1:0] half;
        half        = '0;
        half[s - 1] = 1'b1;
        return (v + half) >>> s;
    endfunction

    // Saturate to the 32-bit filter state range.
    function automatic logic signed [STATE_W-1:0] sat_state(
        input logic signed [WIDE_W-1:0] v
    );
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        hi = WIDE_W'({1'b0, {(STATE_W-1){1'b1}}});
        lo = -hi - WIDE_W'(1);
        if (v > hi) begin
            return hi[STATE_W-1:0];
        end else if (v < lo) begin
            return lo[STATE_W-1:0];
        end
        return v[STATE_W-1:0];
    endfunction

    // Saturate to the sample range.
    function automatic logic signed [SAMPLE_W-1:0] sat_sample(
        input logic signed [WIDE_W-1:0] v
    );
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        hi = WIDE_W'({1'b0, {(SAMPLE_W-1){1'b1}}});
        lo = -hi - WIDE_W'(1);
        if (v > hi) begin
            return hi[SAMPLE_W-1:0];
        end else if (v < lo) begin
            return lo[SAMPLE_W-1:0];
        end
        return v[SAMPLE_W-1:0];
    endfunction

endpackage

// ===== rtl/core/comb_resonator_fractional_delay.sv =====
// Comb resonator with a fractional delay, feedback or feedforward.
// Input samples arrive on the s_axis channel, one 24-bit signed sample per beat.
// Results leave on the m_axis channel, one saturated 24-bit sample per input beat.
// Registers are written through i_cfg_we / i_cfg_idx / i_cfg_data; the user must
// write them only while no sample is in flight, which the block does not enforce.
// Indexes beyond the register list are ignored. One multiplier is shared by all
// products under an eight-state sequencer, so the block takes one sample at a time
// and holds o_s_axis_tready low while busy. Feedback mode steps through X_MUL,
// AP_MUL, AP_ADD, LP_MUL, LP_ADD, MIX_MUL and MIX_ADD; feedforward mode skips the
// loop lowpass states. The serial chain of multiplies through the one unit sets the pace.
// The delay line is a single-port-write memory; entries not yet written since
// reset read as zero through a write-fill flag, so there is no clearing pass.
// Reset clears the pointer, filter state and output valid and restores the
// register defaults. If the receiver stalls, the result stays in the output
// register, one more sample may be accepted and is held in its last step until
// the output register is free.
`include "comb_resonator_fractional_delay_macros.svh"

module comb_resonator_fractional_delay (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Input stream
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [crfd_pkg::SAMPLE_W-1:0]       i_s_axis_tdata,  // [23:0] sample_in
    // Output stream
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    output logic [crfd_pkg::SAMPLE_W-1:0]       o_m_axis_tdata,  // [23:0] sample_out
    // Configuration write port
    input  logic                                i_cfg_we,
    input  logic [crfd_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [crfd_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    // Configuration registers
    logic [crfd_pkg::DELAY_W-1:0]            r_delay_int;
    logic [crfd_pkg::COEF_W-1:0]             r_allpass_coef;
    logic signed [crfd_pkg::SAMPLE_W-1:0]    r_mix_gain;
    logic [crfd_pkg::COEF_W-1:0]             r_loop_coef;
    logic                                    r_topology;
    logic [crfd_pkg::GAIN_W-1:0]             r_input_gain;

    // Sequencer
    crfd_pkg::t_state r_state;
    crfd_pkg::t_state n_state;

    // Filter and pointer state
    logic [crfd_pkg::ADDR_W-1:0]             r_wp;
    logic                                    r_wrapped;
    logic signed [crfd_pkg::STATE_W-1:0]     r_lp;
    logic signed [crfd_pkg::SAMPLE_W-1:0]    r_ap_prev_in;
    logic signed [crfd_pkg::STATE_W-1:0]     r_ap_prev_out;

    // Per-sample working registers
    logic signed [crfd_pkg::SAMPLE_W-1:0]    r_sample;
    logic signed [crfd_pkg::SAMPLE_W-1:0]    r_delayed;
    logic signed [crfd_pkg::X_W-1:0]         r_x;
    logic signed [crfd_pkg::PROD_W-1:0]      r_prod;

    // Delay memory
    logic signed [crfd_pkg::SAMPLE_W-1:0]    r_mem [crfd_pkg::STORE_DEPTH];
    logic signed [crfd_pkg::SAMPLE_W-1:0]    r_rd_q;
    logic                                    r_rd_vld;

    // Output register
    logic                                    r_out_vld;
    logic [crfd_pkg::SAMPLE_W-1:0]           r_out;

    // Combinational helpers
    logic                                    d_lo;
    logic                                    d_hi;
    logic                                    ap_bypass;
    logic                                    lp_bypass;
    logic [crfd_pkg::ADDR_W-1:0]             d_clamp;
    logic [crfd_pkg::ADDR_W-1:0]             rd_addr;
    logic                                    out_free;
    logic                                    commit;
    logic signed [crfd_pkg::MUL_A_W-1:0]     mul_a;
    logic signed [crfd_pkg::MUL_B_W-1:0]     mul_b;
    logic signed [crfd_pkg::WIDE_W-1:0]      rs16;
    logic signed [crfd_pkg::WIDE_W-1:0]      rs23;
    logic signed [crfd_pkg::STATE_W-1:0]     ap_new;
    logic signed [crfd_pkg::STATE_W-1:0]     lp_new;
    logic signed [crfd_pkg::SAMPLE_W-1:0]    y_out;
    logic signed [crfd_pkg::SAMPLE_W-1:0]    stored;

    // Delay clamping; a clamped delay also forces the allpass into bypass.
    assign d_lo      = r_delay_int < crfd_pkg::DELAY_W'(2);
    assign d_hi      = 32'(r_delay_int) > 32'(crfd_pkg::D_MAX);
    assign d_clamp   = d_lo ? crfd_pkg::ADDR_W'(2)
                     : (d_hi ? crfd_pkg::ADDR_W'(crfd_pkg::D_MAX)
                             : crfd_pkg::ADDR_W'(r_delay_int));
    assign ap_bypass = (r_allpass_coef >= crfd_pkg::COEF_ONE) || d_lo || d_hi;
    assign lp_bypass = r_loop_coef >= crfd_pkg::COEF_ONE;
    assign rd_addr   = r_wp - d_clamp;

    // The last step may finish only when the output register is free.
    assign out_free = !r_out_vld || i_m_axis_tready;
    assign commit   = (r_state == crfd_pkg::ST_MIX_ADD) && out_free;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay_int    <= crfd_pkg::RST_DELAY_INT;
            r_allpass_coef <= crfd_pkg::COEF_ONE;
            r_mix_gain     <= crfd_pkg::RST_MIX_GAIN;
            r_loop_coef    <= crfd_pkg::COEF_ONE;
            r_topology     <= 1'b0;
            r_input_gain   <= crfd_pkg::RST_INPUT_GAIN;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                crfd_pkg::CFG_DELAY_INT: begin
                    r_delay_int <= i_cfg_data[crfd_pkg::DELAY_W-1:0];
                end
                crfd_pkg::CFG_ALLPASS_COEF: begin
                    r_allpass_coef <= i_cfg_data[crfd_pkg::COEF_W-1:0];
                end
                crfd_pkg::CFG_MIX_GAIN: begin
                    r_mix_gain <= signed'(i_cfg_data[crfd_pkg::SAMPLE_W-1:0]);
                end
                crfd_pkg::CFG_LOOP_COEF: begin
                    r_loop_coef <= i_cfg_data[crfd_pkg::COEF_W-1:0];
                end
                crfd_pkg::CFG_TOPOLOGY: begin
                    r_topology <= i_cfg_data[0];
                end
                crfd_pkg::CFG_INPUT_GAIN: begin
                    r_input_gain <= i_cfg_data[crfd_pkg::GAIN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= crfd_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and handshake outputs.
    always_comb begin
        n_state = r_state;
        case (r_state)
            crfd_pkg::ST_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_state = crfd_pkg::ST_X_MUL;
                end
            end
            crfd_pkg::ST_X_MUL:   n_state = crfd_pkg::ST_AP_MUL;
            crfd_pkg::ST_AP_MUL:  n_state = crfd_pkg::ST_AP_ADD;
            crfd_pkg::ST_AP_ADD: begin
                n_state = r_topology ? crfd_pkg::ST_MIX_MUL : crfd_pkg::ST_LP_MUL;
            end
            crfd_pkg::ST_LP_MUL:  n_state = crfd_pkg::ST_LP_ADD;
            crfd_pkg::ST_LP_ADD:  n_state = crfd_pkg::ST_MIX_MUL;
            crfd_pkg::ST_MIX_MUL: n_state = crfd_pkg::ST_MIX_ADD;
            crfd_pkg::ST_MIX_ADD: begin
                if (out_free) begin
                    n_state = crfd_pkg::ST_IDLE;
                end
            end
            default: n_state = crfd_pkg::ST_IDLE;
        endcase
    end

    assign o_s_axis_tready = (r_state == crfd_pkg::ST_IDLE);
    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out;

    // Operand select for the shared multiplier.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            crfd_pkg::ST_X_MUL: begin
                mul_a = crfd_pkg::MUL_A_W'(r_input_gain);
                mul_b = crfd_pkg::MUL_B_W'(r_sample);
            end
            crfd_pkg::ST_AP_MUL: begin
                mul_a = crfd_pkg::MUL_A_W'(r_allpass_coef);
                mul_b = crfd_pkg::MUL_B_W'(r_delayed) - crfd_pkg::MUL_B_W'(r_ap_prev_out);
            end
            crfd_pkg::ST_LP_MUL: begin
                mul_a = crfd_pkg::MUL_A_W'(r_loop_coef);
                mul_b = crfd_pkg::MUL_B_W'(r_ap_prev_out) - crfd_pkg::MUL_B_W'(r_lp);
            end
            crfd_pkg::ST_MIX_MUL: begin
                mul_a = r_mix_gain;
                mul_b = r_topology ? crfd_pkg::MUL_B_W'(r_ap_prev_out)
                                   : crfd_pkg::MUL_B_W'(r_lp);
            end
            default: begin
            end
        endcase
    end

    // Post-multiply rounding, saturation and result selection.
    always_comb begin
        rs16   = crfd_pkg::round_shift(crfd_pkg::WIDE_W'(r_prod), 16);
        rs23   = crfd_pkg::round_shift(crfd_pkg::WIDE_W'(r_prod), 23);
        ap_new = ap_bypass ? crfd_pkg::STATE_W'(r_delayed)
               : crfd_pkg::sat_state(crfd_pkg::WIDE_W'(r_ap_prev_in) + rs16);
        lp_new = lp_bypass ? r_ap_prev_out
               : crfd_pkg::sat_state(crfd_pkg::WIDE_W'(r_lp) + rs16);
        y_out  = crfd_pkg::sat_sample(crfd_pkg::WIDE_W'(r_x) + rs23);
        stored = r_topology ? crfd_pkg::sat_sample(crfd_pkg::WIDE_W'(r_x)) : y_out;
    end

    // Working registers of the current sample. The mix product is held while
    // the last step waits for the output register.
    always_ff @(posedge i_clk) begin
        if (r_state != crfd_pkg::ST_MIX_ADD) begin
            r_prod <= mul_a * mul_b;
        end
        case (r_state)
            crfd_pkg::ST_IDLE: begin
                r_sample <= signed'(i_s_axis_tdata);
            end
            crfd_pkg::ST_X_MUL: begin
                r_delayed <= r_rd_vld ? r_rd_q : '0;
            end
            crfd_pkg::ST_AP_MUL: begin
                r_x <= crfd_pkg::X_W'(rs16);
            end
            default: begin
            end
        endcase
    end

    // Filter state, write pointer and fill flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp          <= '0;
            r_wrapped     <= 1'b0;
            r_lp          <= '0;
            r_ap_prev_in  <= '0;
            r_ap_prev_out <= '0;
        end else begin
            if (r_state == crfd_pkg::ST_AP_ADD) begin
                r_ap_prev_in  <= r_delayed;
                r_ap_prev_out <= ap_new;
            end
            if (r_state == crfd_pkg::ST_LP_ADD) begin
                r_lp <= lp_new;
            end
            if (commit) begin
                r_wp <= r_wp + crfd_pkg::ADDR_W'(1);
                if (r_wp == {crfd_pkg::ADDR_W{1'b1}}) begin
                    r_wrapped <= 1'b1;
                end
            end
        end
    end

    // Delay memory: one write, one registered read. Entries below the write
    // pointer, or all of them once it has wrapped, hold written data.
    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_mem[r_wp] <= stored;
        end
        r_rd_q   <= r_mem[rd_addr];
        r_rd_vld <= r_wrapped || (rd_addr < r_wp);
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (commit) begin
            r_out_vld <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_out <= y_out;
        end
    end

    // Checks
    `CRFD_ASSERT_ALWAYS(a_rd_not_wp, rd_addr != r_wp, "delay read hits the write slot")
    `CRFD_ASSERT_NEXT(a_wp_step, commit, r_wp == $past(r_wp) + crfd_pkg::ADDR_W'(1), "write pointer did not advance by one")
    `CRFD_ASSERT_NEXT(a_wrapped_sticky, r_wrapped, r_wrapped, "fill flag dropped after wrap")
    `CRFD_ASSERT_NEXT(a_ap_bypass, (r_state == crfd_pkg::ST_AP_ADD) && ap_bypass, r_ap_prev_out == crfd_pkg::STATE_W'(r_ap_prev_in), "allpass bypass state mismatch")

endmodule
